/* design/btda_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the binary to decimal ASCII converter.
// Depends on nothing; every design file but btda_value_if imports it.
package btda_pkg;

    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 6;

    localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 6'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } btda_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } btda_cmd_t;

    typedef struct packed {
        logic top_zero;
    } btda_status_t;

endpackage

/* design/btda_value_if.sv */
`timescale 1ns / 1ps
// Request channel carrying one binary value to convert.
// Depends on nothing.
interface btda_value_if #(
    parameter int VALUE_BITS = 31
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* design/btda_char_if.sv */
`timescale 1ns / 1ps
// Result channel carrying one ASCII digit and its last marker.
// Depends on btda_pkg.
interface btda_char_if import btda_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

/* design/binary_to_decimal_ascii_core.sv */
`timescale 1ns / 1ps
// Sequence: load the value, one shift-add step per value bit, a shift for each
// suppressed leading zero, then one character per cycle while the sink is ready.
// The single shared double-dabble register takes no new value until the last
// character of the current one has been taken.
// Reset: rst_n is asynchronous and active low; it returns the sequencer to idle.
// Depends on btda_pkg, btda_value_if, btda_char_if, btda_ctrl, btda_datapath.
module binary_to_decimal_ascii_core import btda_pkg::*; #(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    btda_value_if.sink  number,
    btda_char_if.source text
);

    btda_cmd_t    cmd;
    btda_status_t status;

    // The sequencer owns the handshakes and the bit and digit counters.
    // A request is taken only in idle; the next one waits until the last
    // character of the current value has been taken.
    btda_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (number.valid),
        .in_ready  (number.ready),
        .out_valid (text.valid),
        .out_ready (text.ready),
        .out_last  (text.last),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the value and its BCD image; the top digit of the
    // BCD register is the character on offer, so it stays put while stalled.
    btda_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk        (clk),
        .value      (number.value),
        .cmd        (cmd),
        .status     (status),
        .digit_char (text.digit_char)
    );

endmodule

/* design/btda_datapath.sv */
`timescale 1ns / 1ps
// Double-dabble datapath: value shift register and packed BCD digit register.
// Depends on btda_pkg.
module btda_datapath import btda_pkg::*; #(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 10
) (
    input  logic                  clk,
    input  logic [VALUE_BITS-1:0] value,
    input  btda_cmd_t             cmd,
    output btda_status_t          status,
    output logic [CHAR_W-1:0]     digit_char
);

    localparam int BCD_W = DIGIT_W * MAX_DIGITS;

    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic [BCD_W-1:0]      bcd_adj;
    logic [DIGIT_W-1:0]    top_digit;

    // Add three to every digit of five or more before the doubling shift.
    always_comb
    begin
        for (int d = 0; d < MAX_DIGITS; d++)
        begin
            if (bcd_reg[d*DIGIT_W +: DIGIT_W] >= DIGIT_ADJ_MIN)
            begin
                bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
            end
            else
            begin
                bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb
    begin
        val_next = val_reg;
        bcd_next = bcd_reg;
        if (cmd.load)
        begin
            val_next = value;
            bcd_next = '0;
        end
        else if (cmd.step)
        begin
            // Carry out of the top digit drops: the count wraps modulo 10^MAX_DIGITS.
            val_next = {val_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], val_reg[VALUE_BITS-1]};
        end
        else if (cmd.shift)
        begin
            bcd_next = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit       = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign status.top_zero = (top_digit == '0);
    assign digit_char      = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};

endmodule

/* design/btda_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the converter: load, shift-add, leading-zero skip, emit.
// Depends on btda_pkg.
module btda_ctrl import btda_pkg::*; #(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         out_last,
    input  btda_status_t status,
    output btda_cmd_t    cmd
);

    localparam int BIT_CNT_W = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W = $clog2(MAX_DIGITS);

    btda_state_t          state_reg;
    btda_state_t          state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_next;
    logic [DIG_CNT_W-1:0] dig_cnt_reg;
    logic [DIG_CNT_W-1:0] dig_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        out_last     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = BIT_CNT_W'(VALUE_BITS - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.step = 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_CNT_W'(MAX_DIGITS - 1);
                    state_next   = ST_SKIP;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros, but always keep the last digit.
                if (status.top_zero && (dig_cnt_reg != '0))
                begin
                    cmd.shift    = 1'b1;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                out_last  = (dig_cnt_reg == '0);
                if (out_ready)
                begin
                    if (dig_cnt_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.shift    = 1'b1;
                        dig_cnt_next = dig_cnt_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/btda_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the converter core, and the bind that attaches them.
// Depends on btda_pkg and binary_to_decimal_ascii_core.
module btda_checker import btda_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAR_W-1:0] out_char,
    input logic              out_last
);

    // Hold a stalled character.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
        else $error("stalled character changed");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while characters pending");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char >= 6'd48) && (out_char <= 6'd57))
        else $error("character is not a decimal digit");

    a_conv_delay: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid && !in_ready)
        else $error("result offered right after request");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid)
        else $error("character offered after last");

endmodule

bind binary_to_decimal_ascii_core btda_checker u_btda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .out_char  (text.digit_char),
    .out_last  (text.last)
);

/* tb/sv/binary_to_decimal_ascii_core_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the binary to decimal ASCII converter: predicts the digit string
// of every accepted value and compares each accepted character against it.
// Depends on btda_pkg; watches the value and character channels of the top.
module binary_to_decimal_ascii_core_checker import btda_pkg::*; #(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  value_valid,
    input  logic                  value_ready,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  char_valid,
    input  logic                  char_ready,
    input  logic [CHAR_W-1:0]     digit_char,
    input  logic                  last,
    output int                    failures,
    output int                    pending,
    output int                    values_seen,
    output int                    chars_seen
);

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } digit_entry_t;

    digit_entry_t expected_digits [$];
    digit_entry_t oldest;

    // Split the value into MAX_DIGITS decimal digits (upper digits drop off),
    // then queue them most significant first with leading zeros suppressed.
    task automatic queue_decimal_digits(input logic [VALUE_BITS-1:0] v);
        logic [DIGIT_W-1:0] digits [MAX_DIGITS];
        longint unsigned    rest;
        int                 count;
        digit_entry_t       entry;
        rest  = 64'(v);
        count = 1;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            digits[i] = DIGIT_W'(rest % 10);
            rest      = rest / 10;
            if (digits[i] != '0)
                count = i + 1;
        end
        for (int pos = count - 1; pos >= 0; pos--)
        begin
            entry.digit_char = ASCII_ZERO + CHAR_W'(digits[pos]);
            entry.last       = (pos == 0);
            expected_digits.push_back(entry);
        end
    endtask

    initial
    begin
        failures    = 0;
        pending     = 0;
        values_seen = 0;
        chars_seen  = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (value_valid && value_ready)
            begin
                queue_decimal_digits(value);
                values_seen++;
            end
            if (char_valid && char_ready)
            begin
                chars_seen++;
                if (expected_digits.size() == 0)
                begin
                    $display("%0t: unexpected character: expected none, got char %0d last %b",
                             $time, digit_char, last);
                    failures++;
                end
                else
                begin
                    oldest = expected_digits.pop_front();
                    if (digit_char !== oldest.digit_char)
                    begin
                        $display("%0t: digit_char mismatch: expected %0d, got %0d",
                                 $time, oldest.digit_char, digit_char);
                        failures++;
                    end
                    if (last !== oldest.last)
                    begin
                        $display("%0t: last mismatch: expected %b, got %b",
                                 $time, oldest.last, last);
                        failures++;
                    end
                end
            end
        end
        pending = expected_digits.size();
    end

endmodule

/* tb/sv/binary_to_decimal_ascii_core_test.sv */
`timescale 1ns / 1ps
// Top of the converter testbench: clock, reset, value requests and character
// back-pressure; the checker beside the block does all prediction and comparison.
// Depends on btda_pkg, btda_value_if, btda_char_if, the core and the checker module.
module binary_to_decimal_ascii_core_test;
    import btda_pkg::*;

    localparam int VALUE_BITS = 31;
    localparam int MAX_DIGITS = 10;
    localparam int RANDOM_REQUESTS = 80;
    // Longest quiet spell of a correct run is one conversion plus the sink's
    // stalls; allow many times that before giving up.
    localparam int QUIET_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic no_gaps;   // when set, neither side idles or stalls

    int failures;
    int pending;
    int values_seen;
    int chars_seen;
    int quiet_cycles;

    int unsigned directed_values [0:19];

    btda_value_if #(.VALUE_BITS(VALUE_BITS)) number ();
    btda_char_if                             text ();

    binary_to_decimal_ascii_core #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .number(number),
        .text  (text)
    );

    binary_to_decimal_ascii_core_checker #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .value_valid(number.valid),
        .value_ready(number.ready),
        .value      (number.value),
        .char_valid (text.valid),
        .char_ready (text.ready),
        .digit_char (text.digit_char),
        .last       (text.last),
        .failures   (failures),
        .pending    (pending),
        .values_seen(values_seen),
        .chars_seen (chars_seen)
    );

    // 10 ns clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: count cycles in which neither channel moves anything.
    initial quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((number.valid && number.ready) || (text.valid && text.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("binary_to_decimal_ascii_core regression: fail");
            $finish;
        end
    end

    // Present one value request. Idle with valid low for a random gap first (unless
    // gaps are off), then hold valid and the value until the block takes it.
    // Drive only at falling edges; a gap of zero keeps valid high back to back.
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            number.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        number.valid <= 1'b1;
        number.value <= v;
        @(posedge clk);
        while (!(number.valid && number.ready))
            @(posedge clk);
    endtask

    // Draw a value by decimal length so short and long strings both show up
    // often; now and then take a fully random 31-bit pattern instead.
    function automatic logic [VALUE_BITS-1:0] pick_value();
        int              digits;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned span;
        if ($urandom_range(0, 7) == 0)
            return VALUE_BITS'($urandom);
        digits = $urandom_range(1, MAX_DIGITS);
        hi = 1;
        for (int i = 0; i < digits; i++)
            hi = hi * 10;
        lo = (digits == 1) ? 0 : hi / 10;
        hi = hi - 1;
        if (hi > (64'd1 << VALUE_BITS) - 1)
            hi = (64'd1 << VALUE_BITS) - 1;
        span = hi - lo + 1;
        return VALUE_BITS'(lo + ({$urandom, $urandom} % span));
    endfunction

    // Character sink: before each character hold ready low for a random stall,
    // possibly none, then hold ready until a character is taken.
    initial
    begin : drain
        int stall;
        text.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            @(negedge clk);
            if (stall > 0)
            begin
                text.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            text.ready <= 1'b1;
            @(posedge clk);
            while (!(text.valid && text.ready))
                @(posedge clk);
        end
    end

    // Main sequence: reset, directed edge values, random values in phases
    // with and without idling, then drain and give the verdict.
    initial
    begin
        number.valid <= 1'b0;
        number.value <= '0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero, one-digit limits, some carries into a new digit count, the
        // largest 31-bit values and the all-ones 31-bit input.
        directed_values = '{
            0, 1, 9, 10, 11, 99, 100, 101, 1000, 65535,
            65536, 999999, 1000000, 123456789, 999999999, 1000000000,
            1234567890, 1073741824, 2147483646, 2147483647
        };
        foreach (directed_values[i])
            send_value(VALUE_BITS'(directed_values[i]));

        // Random phases: a back-to-back stretch between two idling stretches.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            no_gaps = (n >= RANDOM_REQUESTS / 3) && (n < RANDOM_REQUESTS / 2);
            send_value(pick_value());
        end
        no_gaps = 1'b0;
        @(negedge clk);
        number.valid <= 1'b0;

        // Drain: wait for every predicted character, then give the block a
        // full conversion's worth of cycles to show any stray output.
        while (pending != 0)
            @(posedge clk);
        repeat (VALUE_BITS + MAX_DIGITS + 8) @(posedge clk);

        $display("Converted %0d values into %0d digit characters,", values_seen, chars_seen);
        $display("from zero to the 31-bit maximum, with random idling on both sides.");
        if (failures == 0 && pending == 0)
            $display("binary_to_decimal_ascii_core regression: pass");
        else
            $display("binary_to_decimal_ascii_core regression: fail");
        $finish;
    end

endmodule

/* sim.f */
design/btda_pkg.sv
design/btda_value_if.sv
design/btda_char_if.sv
design/btda_datapath.sv
design/btda_ctrl.sv
design/binary_to_decimal_ascii_core.sv
design/btda_checker.sv
tb/sv/binary_to_decimal_ascii_core_checker.sv
tb/sv/binary_to_decimal_ascii_core_test.sv
